FILE: src/dcrm_pkg.sv
// Package: sizes, state encoding and control/status types of the contiguous run mapper.
package dcrm_pkg;

  localparam int MAX_PAGES = 256;
  localparam int PAGE_BITS = 12;

  localparam int CFG_W   = 12;
  localparam int SLOT_W  = 8;
  localparam int FRAME_W = 20;
  localparam int OFS_W   = 20;
  localparam int LEN_W   = 21;
  localparam int ADDR_W  = 32;

  localparam int IDX_W = $clog2(MAX_PAGES);
  localparam int POS_W = OFS_W + 1;
  localparam int PG_W  = POS_W - PAGE_BITS;

  localparam logic [LEN_W-1:0] PAGE_LEN = LEN_W'(2 ** PAGE_BITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_FIRST,
    S_WALK
  } dcrm_state_e;

  typedef struct packed {
    logic load_wr;
    logic accept_map;
    logic start;
    logic first;
    logic walk;
  } dcrm_cmd_t;

  typedef struct packed {
    logic page_err;
    logic stop;
  } dcrm_sts_t;

endpackage

FILE: src/dcrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dcrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/dcrm_ctrl.sv
// Controller: item acceptance, map sequencing and result strobe.
module dcrm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              operation_i,
  input  dcrm_pkg::dcrm_sts_t sts_i,
  output dcrm_pkg::dcrm_cmd_t cmd_o,
  output logic              busy_o,
  output logic              done_o
);
  import dcrm_pkg::*;

  dcrm_state_e state_q, state_d;
  logic        done_q, done_d;
  logic        accept;

  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && operation_i) state_d = S_START;
      end
      S_START: begin
        state_d = sts_i.page_err ? S_IDLE : S_FIRST;
      end
      S_FIRST, S_WALK: begin
        state_d = sts_i.stop ? S_IDLE : S_WALK;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.load_wr    = accept && !operation_i;
    cmd_o.accept_map = accept && operation_i;
    done_d           = 1'b0;
    case (state_q)
      S_START: begin
        cmd_o.start = 1'b1;
        done_d      = sts_i.page_err;
      end
      S_FIRST: begin
        cmd_o.first = 1'b1;
        done_d      = sts_i.stop;
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        done_d     = sts_i.stop;
      end
      default: done_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

FILE: src/dcrm_dp.sv
// Datapath: offset register, page arithmetic, run accumulation and result registers.
module dcrm_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dcrm_pkg::dcrm_cmd_t             cmd_i,
  output dcrm_pkg::dcrm_sts_t             sts_o,
  input  logic                            cfg_we_i,
  input  logic [dcrm_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic [dcrm_pkg::SLOT_W-1:0]     page_slot_i,
  input  logic [dcrm_pkg::FRAME_W-1:0]    frame_number_i,
  input  logic [dcrm_pkg::OFS_W-1:0]      transfer_offset_i,
  input  logic [dcrm_pkg::LEN_W-1:0]      request_length_i,
  output logic                            ram_we_o,
  output logic [dcrm_pkg::IDX_W-1:0]      ram_waddr_o,
  output logic [dcrm_pkg::FRAME_W-1:0]    ram_wdata_o,
  output logic [dcrm_pkg::IDX_W-1:0]      ram_raddr_o,
  input  logic [dcrm_pkg::FRAME_W-1:0]    ram_rdata_i,
  output logic [dcrm_pkg::ADDR_W-1:0]     bus_address_o,
  output logic [dcrm_pkg::LEN_W-1:0]      run_length_o,
  output logic                            range_error_o
);
  import dcrm_pkg::*;

  logic [CFG_W-1:0]     cfg_q;
  logic [POS_W-1:0]     pos_q;
  logic [LEN_W-1:0]     req_q;
  logic [IDX_W-1:0]     idx_q;
  logic [FRAME_W-1:0]   prev_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [LEN_W-1:0]     run_q;
  logic                 err_q;

  logic [PG_W-1:0]      page;
  logic [PAGE_BITS-1:0] in_page;
  logic                 last;
  logic [LEN_W-1:0]     head_len;
  logic [LEN_W-1:0]     run_f;
  logic [LEN_W-1:0]     rem;
  logic [LEN_W-1:0]     run_w;
  logic                 match;
  logic                 cont_f;
  logic                 cont_w;

  assign page    = pos_q[POS_W-1:PAGE_BITS];
  assign in_page = pos_q[PAGE_BITS-1:0];
  assign last    = (32'(idx_q) == 32'(MAX_PAGES - 1));

  assign head_len = PAGE_LEN - LEN_W'(in_page);
  assign run_f    = (head_len < req_q) ? head_len : req_q;
  assign cont_f   = (run_f < req_q) && !last;

  assign rem    = req_q - run_q;
  assign run_w  = run_q + ((PAGE_LEN < rem) ? PAGE_LEN : rem);
  assign match  = ({1'b0, ram_rdata_i} == ({1'b0, prev_q} + (FRAME_W + 1)'(1)));
  assign cont_w = match && (run_w < req_q) && !last;

  assign sts_o.page_err = (32'(page) >= 32'(MAX_PAGES));
  assign sts_o.stop     = cmd_i.first ? !cont_f : !cont_w;

  assign ram_we_o    = cmd_i.load_wr && (32'(page_slot_i) < 32'(MAX_PAGES));
  assign ram_waddr_o = IDX_W'(page_slot_i);
  assign ram_wdata_o = frame_number_i;
  assign ram_raddr_o = cmd_i.start ? IDX_W'(page) : idx_q + IDX_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_map) begin
      pos_q <= POS_W'(cfg_q) + POS_W'(transfer_offset_i);
      req_q <= request_length_i;
    end
    if (cmd_i.start) begin
      idx_q <= IDX_W'(page);
      if (sts_o.page_err) begin
        addr_q <= '0;
        run_q  <= '0;
        err_q  <= 1'b1;
      end
    end
    if (cmd_i.first) begin
      prev_q <= ram_rdata_i;
      addr_q <= ADDR_W'({ram_rdata_i, in_page});
      run_q  <= run_f;
      err_q  <= 1'b0;
      idx_q  <= idx_q + IDX_W'(1);
    end
    if (cmd_i.walk && match) begin
      prev_q <= ram_rdata_i;
      run_q  <= run_w;
      idx_q  <= idx_q + IDX_W'(1);
    end
  end

  assign bus_address_o = addr_q;
  assign run_length_o  = run_q;
  assign range_error_o = err_q;

endmodule

FILE: src/dma_contiguous_run_mapper.sv
// Top level: contiguous run mapper over a table of page frame numbers.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------------
//  item in  | start_i & !busy_o          | operation_i, page_slot_i, frame_number_i,
//           |                            | transfer_offset_i, request_length_i
//  result   | done_o (one cycle)         | bus_address_o, run_length_o, range_error_o
//  config   | first_page_offset_we_i     | first_page_offset_i
//
// Load item: busy stays low, table write at the accepting edge, no result.
// Map item: a start step reads the start page's frame, a first step maps that page, then
// walk steps add pages while frames follow on and length remains (one frame-table read per
// cycle); a start page beyond the table ends the item in the start step, with no walk.
// The result strobe comes in the same cycle that busy drops; a new item may be taken then.
// Reset clears the controller and the offset register; the table is undefined until loaded.
// Results cannot be stalled.
module dma_contiguous_run_mapper (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  output logic                            done_o,
  input  logic                            first_page_offset_we_i,
  input  logic [dcrm_pkg::CFG_W-1:0]      first_page_offset_i,
  input  logic                            operation_i,
  input  logic [dcrm_pkg::SLOT_W-1:0]     page_slot_i,
  input  logic [dcrm_pkg::FRAME_W-1:0]    frame_number_i,
  input  logic [dcrm_pkg::OFS_W-1:0]      transfer_offset_i,
  input  logic [dcrm_pkg::LEN_W-1:0]      request_length_i,
  output logic [dcrm_pkg::ADDR_W-1:0]     bus_address_o,
  output logic [dcrm_pkg::LEN_W-1:0]      run_length_o,
  output logic                            range_error_o
);
  import dcrm_pkg::*;

  dcrm_cmd_t          cmd;
  dcrm_sts_t          sts;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [FRAME_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [FRAME_W-1:0] ram_rdata;

  dcrm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy_o),
    .done_o      (done_o)
  );

  dcrm_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (first_page_offset_we_i),
    .cfg_data_i        (first_page_offset_i),
    .page_slot_i       (page_slot_i),
    .frame_number_i    (frame_number_i),
    .transfer_offset_i (transfer_offset_i),
    .request_length_i  (request_length_i),
    .ram_we_o          (ram_we),
    .ram_waddr_o       (ram_waddr),
    .ram_wdata_o       (ram_wdata),
    .ram_raddr_o       (ram_raddr),
    .ram_rdata_i       (ram_rdata),
    .bus_address_o     (bus_address_o),
    .run_length_o      (run_length_o),
    .range_error_o     (range_error_o)
  );

  dcrm_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (MAX_PAGES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

FILE: tb/dma_contiguous_run_mapper_test.sv
// Self-checking testbench for the contiguous run mapper: table loads, run maps, offset changes.
module dma_contiguous_run_mapper_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dcrm_pkg::*;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MAP  = 1'b1;
  localparam int PG_BYTES  = 1 << PAGE_BITS;
  localparam int FULL_REQ  = 1 << OFS_W;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic              err;
  } run_result_t;

  class frame_run_scoreboard;
    logic [FRAME_W-1:0] frames [MAX_PAGES];
    logic [CFG_W-1:0]   page_ofs;
    run_result_t        pending_runs [$];
    int errors, loads, maps, range_hits, zero_reqs, end_hits, longest;

    function new();
      page_ofs = '0;
      errors = 0;
      loads = 0;
      maps = 0;
      range_hits = 0;
      zero_reqs = 0;
      end_hits = 0;
      longest = 0;
    endfunction

    task flag_mismatch(string what);
      errors++;
      $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    function run_result_t expected_run(logic [OFS_W-1:0] ofs, logic [LEN_W-1:0] req);
      run_result_t r;
      logic [POS_W-1:0] pos;
      int page, in_page, run, reqi, prev, idx;
      r = '0;
      pos = POS_W'(ofs) + POS_W'(page_ofs);
      page = int'(pos >> PAGE_BITS);
      in_page = int'(pos[PAGE_BITS-1:0]);
      reqi = int'(req);
      if (reqi == 0) zero_reqs++;
      if (page >= MAX_PAGES) begin
        r.err = 1'b1;
        range_hits++;
        return r;
      end
      prev = int'(frames[page]);
      r.addr = (ADDR_W'(frames[page]) << PAGE_BITS) + ADDR_W'(in_page);
      run = (PG_BYTES - in_page < reqi) ? PG_BYTES - in_page : reqi;
      idx = page + 1;
      // pages chain while each frame is exactly one above the last
      while (run < reqi && idx < MAX_PAGES && int'(frames[idx]) == prev + 1) begin
        run += (reqi - run < PG_BYTES) ? reqi - run : PG_BYTES;
        prev++;
        idx++;
      end
      if (run < reqi && idx == MAX_PAGES) end_hits++;
      if (idx - page > longest) longest = idx - page;
      r.len = LEN_W'(run);
      return r;
    endfunction

    function void note_item(logic op, logic [SLOT_W-1:0] slot, logic [FRAME_W-1:0] frame,
                            logic [OFS_W-1:0] ofs, logic [LEN_W-1:0] req);
      if (op == OP_LOAD) begin
        loads++;
        if (int'(slot) < MAX_PAGES) frames[slot] = frame;
      end else begin
        maps++;
        pending_runs.push_back(expected_run(ofs, req));
      end
    endfunction

    task check_run(logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len, logic err);
      run_result_t want;
      if (pending_runs.size() == 0) begin
        flag_mismatch("result strobe with no map item outstanding");
        return;
      end
      want = pending_runs.pop_front();
      if (addr !== want.addr)
        flag_mismatch($sformatf("bus_address %h, expected %h", addr, want.addr));
      if (len !== want.len)
        flag_mismatch($sformatf("run_length %0d, expected %0d", len, want.len));
      if (err !== want.err)
        flag_mismatch($sformatf("range_error %b, expected %b", err, want.err));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic                done_o;
  logic                first_page_offset_we_i;
  logic [CFG_W-1:0]    first_page_offset_i;
  logic                operation_i;
  logic [SLOT_W-1:0]   page_slot_i;
  logic [FRAME_W-1:0]  frame_number_i;
  logic [OFS_W-1:0]    transfer_offset_i;
  logic [LEN_W-1:0]    request_length_i;
  logic [ADDR_W-1:0]   bus_address_o;
  logic [LEN_W-1:0]    run_length_o;
  logic                range_error_o;

  frame_run_scoreboard sb;
  int idle_pct;

  dma_contiguous_run_mapper dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .start_i                (start_i),
    .busy_o                 (busy_o),
    .done_o                 (done_o),
    .first_page_offset_we_i (first_page_offset_we_i),
    .first_page_offset_i    (first_page_offset_i),
    .operation_i            (operation_i),
    .page_slot_i            (page_slot_i),
    .frame_number_i         (frame_number_i),
    .transfer_offset_i      (transfer_offset_i),
    .request_length_i       (request_length_i),
    .bus_address_o          (bus_address_o),
    .run_length_o           (run_length_o),
    .range_error_o          (range_error_o)
  );

  always #5ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) sb.check_run(bus_address_o, run_length_o, range_error_o);
  end

  // Called at a falling edge; returns at a falling edge with no assignment made there yet.
  task automatic send_item(logic op, logic [SLOT_W-1:0] slot, logic [FRAME_W-1:0] frame,
                           logic [OFS_W-1:0] ofs, logic [LEN_W-1:0] req);
    start_i <= 1'b1;
    operation_i <= op;
    page_slot_i <= slot;
    frame_number_i <= frame;
    transfer_offset_i <= ofs;
    request_length_i <= req;
    do @(posedge clk_i); while (busy_o);
    sb.note_item(op, slot, frame, ofs, req);
    @(negedge clk_i);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  task automatic send_map(logic [OFS_W-1:0] ofs, logic [LEN_W-1:0] req);
    send_item(OP_MAP, SLOT_W'($urandom), FRAME_W'($urandom), ofs, req);
  endtask

  task automatic load_run(int slot0, int count, logic [FRAME_W-1:0] base);
    for (int j = 0; j < count && slot0 + j < MAX_PAGES; j++)
      send_item(OP_LOAD, SLOT_W'(slot0 + j), base + FRAME_W'(j), OFS_W'($urandom),
                LEN_W'($urandom_range(FULL_REQ)));
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (sb.pending_runs.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_page_ofs(logic [CFG_W-1:0] value);
    first_page_offset_we_i <= 1'b1;
    first_page_offset_i <= value;
    @(negedge clk_i);
    first_page_offset_we_i <= 1'b0;
    sb.page_ofs = value;
  endtask

  task automatic random_map();
    int cfg, pos, hi, in_page, u;
    logic [OFS_W-1:0] ofs;
    logic [LEN_W-1:0] req;
    cfg = int'(sb.page_ofs);
    u = $urandom_range(99);
    if (u < 8) begin
      ofs = OFS_W'($urandom);
    end else if (u < 16 && cfg > 0) begin
      ofs = OFS_W'($urandom_range(FULL_REQ - 1, FULL_REQ - cfg));
    end else begin
      hi = (MAX_PAGES << PAGE_BITS) - 1;
      if (hi > cfg + FULL_REQ - 1) hi = cfg + FULL_REQ - 1;
      pos = $urandom_range(hi, cfg);
      if ($urandom_range(3) == 0) begin
        pos = (pos & ~(PG_BYTES - 1)) | ($urandom_range(1) ? PG_BYTES - 1 : 0);
        if (pos < cfg) pos = cfg;
      end
      ofs = OFS_W'(pos - cfg);
    end
    in_page = (cfg + int'(ofs)) & (PG_BYTES - 1);
    u = $urandom_range(99);
    if (u < 5) req = '0;
    else if (u < 10) req = LEN_W'(FULL_REQ);
    else if (u < 45) req = LEN_W'($urandom_range(2 * PG_BYTES, 1));
    else if (u < 75) req = LEN_W'($urandom_range(16 * PG_BYTES, 1));
    else if (u < 90) req = LEN_W'($urandom_range(FULL_REQ, 1));
    else req = LEN_W'($urandom_range(8, 1) * PG_BYTES - in_page);
    send_map(ofs, req);
  endtask

  task automatic run_phase(int n, int idle);
    int k, u, cnt, slot;
    logic [FRAME_W-1:0] frame;
    idle_pct = idle;
    k = 0;
    while (k < n) begin
      u = $urandom_range(99);
      if (u < 6) begin
        cnt = $urandom_range(24, 2);
        frame = ($urandom_range(9) == 0) ? FRAME_W'(20'hFFFFF - $urandom_range(cnt - 1))
                                         : FRAME_W'($urandom);
        load_run($urandom_range(MAX_PAGES - 1), cnt, frame);
        k += cnt;
      end else if (u < 28) begin
        slot = $urandom_range(MAX_PAGES - 1);
        u = $urandom_range(9);
        if (u < 6 && slot > 0) frame = sb.frames[slot - 1] + 1'b1;
        else if (u == 6) frame = '1;
        else frame = FRAME_W'($urandom);
        send_item(OP_LOAD, SLOT_W'(slot), frame, OFS_W'($urandom),
                  LEN_W'($urandom_range(FULL_REQ)));
        k++;
      end else begin
        random_map();
        k++;
      end
      if ($urandom_range(99) < 2) drain_results();
    end
  endtask

  initial begin
    int waited;
    sb = new();
    idle_pct = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    first_page_offset_we_i = 1'b0;
    first_page_offset_i = '0;
    operation_i = OP_LOAD;
    page_slot_i = '0;
    frame_number_i = '0;
    transfer_offset_i = '0;
    request_length_i = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // whole table as one run ending at the top frame
    load_run(0, MAX_PAGES, FRAME_W'((1 << FRAME_W) - MAX_PAGES));
    send_map('0, '0);
    send_map('0, LEN_W'(FULL_REQ));
    send_map('1, LEN_W'(FULL_REQ));
    send_map(OFS_W'(200 * PG_BYTES + 5), LEN_W'(12345));
    send_item(OP_LOAD, SLOT_W'(9), 20'hFFFFE, '0, '0);
    send_item(OP_LOAD, SLOT_W'(10), 20'hFFFFF, '1, '1);
    send_item(OP_LOAD, SLOT_W'(11), 20'h00000, '0, '0);
    send_item(OP_LOAD, SLOT_W'(12), 20'h00001, '0, '0);
    send_map(OFS_W'(10 * PG_BYTES), LEN_W'(2 * PG_BYTES));
    send_map(OFS_W'(9 * PG_BYTES + 100), LEN_W'(FULL_REQ));
    send_map(OFS_W'(11 * PG_BYTES + 7), LEN_W'(3 * PG_BYTES));
    send_map('0, LEN_W'(1));
    drain_results();
    write_page_ofs('1);
    send_map(OFS_W'(FULL_REQ - PG_BYTES), LEN_W'(5000));
    send_map(OFS_W'(FULL_REQ - PG_BYTES + 1), '0);
    send_map('1, LEN_W'(FULL_REQ));
    send_map('0, LEN_W'(FULL_REQ));

    drain_results();
    write_page_ofs(CFG_W'($urandom_range(PG_BYTES - 2, 1)));
    run_phase(160, 37);
    drain_results();
    write_page_ofs('0);
    run_phase(160, 51);
    drain_results();
    write_page_ofs(CFG_W'($urandom_range(PG_BYTES - 2, 1)));
    run_phase(160, 0);

    start_i <= 1'b0;
    waited = 0;
    while (sb.pending_runs.size() != 0 && waited < 2000) begin
      @(negedge clk_i);
      waited++;
    end
    if (sb.pending_runs.size() != 0)
      sb.flag_mismatch($sformatf("%0d map results never arrived", sb.pending_runs.size()));
    repeat (300) @(negedge clk_i);

    $display("Ran %0d table loads and %0d maps: %0d out of range, %0d zero length,",
             sb.loads, sb.maps, sb.range_hits, sb.zero_reqs);
    $display("%0d runs cut at the table end, longest run %0d pages, offsets 0, 4095 and random.",
             sb.end_hits, sb.longest);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Timeout: simulation did not reach its end");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
